[rtl/swlrl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swlrl_pkg
// Shared types, codes and field widths of the sliding-window-log rate limiter.
// ----------------------------------------------------------------------------
package swlrl_pkg;

    localparam int CLIENT_W = 4;
    localparam int LIMIT_W  = 5;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic
    {
        ACTION_REGISTER = 1'b0,
        ACTION_REQUEST  = 1'b1
    } swlrl_action_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_EXISTS    = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_LIMITED   = 2'd3
    } swlrl_status_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EXPIRE,
        ST_DECIDE,
        ST_FINISH
    } swlrl_state_t;

    // controller to datapath
    typedef struct packed
    {
        logic clear;
        logic load_item;
        logic lookup;
        logic expire;
        logic decide;
        logic out_load;
    } swlrl_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic clear_done;
        logic in_range;
        logic is_request;
        logic rec_valid;
        logic count_nz;
        logic expire_hit;
        logic more_left;
    } swlrl_stat_t;

endpackage
`default_nettype wire

[rtl/swlrl_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swlrl_req_if
// Input channel: register and rate check requests with valid/ready.
// ----------------------------------------------------------------------------
interface swlrl_req_if;
    import swlrl_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [CLIENT_W-1:0] client;
    logic [LIMIT_W-1:0]  limit;
    logic [TIME_W-1:0]   window;
    logic [TIME_W-1:0]   now;

    modport source
    (
        output valid, action, client, limit, window, now,
        input  ready
    );

    modport sink
    (
        input  valid, action, client, limit, window, now,
        output ready
    );
endinterface
`default_nettype wire

[rtl/swlrl_resp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swlrl_resp_if
// Output channel: status and window count with valid/ready.
// ----------------------------------------------------------------------------
interface swlrl_resp_if;
    import swlrl_pkg::*;

    logic                valid;
    logic                ready;
    swlrl_status_t       status;
    logic [COUNT_W-1:0]  in_window;

    modport source
    (
        output valid, status, in_window,
        input  ready
    );

    modport sink
    (
        input  valid, status, in_window,
        output ready
    );
endinterface
`default_nettype wire

[rtl/swlrl_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swlrl_ctrl
// Sequencer: clear sweep, lookup, expiry walk, decision and result handoff.
// ----------------------------------------------------------------------------
module swlrl_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  swlrl_pkg::swlrl_stat_t stat,
    output swlrl_pkg::swlrl_cmd_t  cmd
);
    import swlrl_pkg::*;

    swlrl_state_t state_reg;
    swlrl_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (stat.in_range && stat.is_request && stat.rec_valid)
                begin
                    state_next = stat.count_nz ? ST_EXPIRE : ST_DECIDE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_EXPIRE:
            begin
                cmd.expire = 1'b1;
                if (!(stat.expire_hit && stat.more_left))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.out_load = slot_free;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[rtl/swlrl_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swlrl_dp
// Datapath: client record memory, timestamp ring memory, expiry compare,
// admission compare and the result registers.
// ----------------------------------------------------------------------------
module swlrl_dp
#(
    parameter int CLIENTS   = 16,
    parameter int MAX_LIMIT = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  swlrl_pkg::swlrl_cmd_t               cmd,
    output swlrl_pkg::swlrl_stat_t              stat,
    input  logic                                in_action,
    input  logic [swlrl_pkg::CLIENT_W-1:0]      in_client,
    input  logic [swlrl_pkg::LIMIT_W-1:0]       in_limit,
    input  logic [swlrl_pkg::TIME_W-1:0]        in_window,
    input  logic [swlrl_pkg::TIME_W-1:0]        in_now,
    output swlrl_pkg::swlrl_status_t            out_status,
    output logic [swlrl_pkg::COUNT_W-1:0]       out_in_window
);
    import swlrl_pkg::*;

    localparam int CIDX_W      = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int SLOT_W      = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
    localparam int CNT_W       = $clog2(MAX_LIMIT + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int ADDR_W      = CIDX_W + SLOT_W;
    localparam int STAMP_DEPTH = CLIENTS * (2 ** SLOT_W);

    typedef struct packed
    {
        logic              valid;
        logic [CNT_W-1:0]  limit;
        logic [TIME_W-1:0] window;
        logic [SLOT_W-1:0] oldest;
        logic [CNT_W-1:0]  count;
    } rec_t;

    // per-client records, cleared by the sweep after reset
    rec_t               rec_mem [0:CLIENTS-1];
    rec_t               rec_rd_reg;
    rec_t               rec_wr_data;
    logic               rec_we;
    logic [CIDX_W-1:0]  rec_wr_addr;
    logic [CIDX_W-1:0]  rec_rd_addr;

    // timestamp rings, one row of slots per client
    logic [TIME_W-1:0]  stamp_mem [0:STAMP_DEPTH-1];
    logic [TIME_W-1:0]  stamp_rd_reg;
    logic [ADDR_W-1:0]  stamp_rd_addr;
    logic [ADDR_W-1:0]  stamp_wr_addr;
    logic               stamp_we;

    logic [CIDX_W-1:0]  clr_ptr_reg;

    logic               action_reg;
    logic               in_range_reg;
    logic [CIDX_W-1:0]  cidx_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [TIME_W-1:0]  window_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [SLOT_W-1:0]  oldest_reg;
    logic [CNT_W-1:0]   count_reg;

    swlrl_status_t      res_status_reg;
    logic [CNT_W-1:0]   res_count_reg;
    swlrl_status_t      out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [SLOT_W-1:0]  oldest_inc;
    logic [SUM_W-1:0]   slot_sum;
    logic [SUM_W-1:0]   slot_wrap;
    logic [SLOT_W-1:0]  free_slot;
    logic [TIME_W-1:0]  age;
    logic               expire_hit;
    logic               room;
    logic [CNT_W-1:0]   count_new;
    logic               new_client;
    logic [CNT_W-1:0]   limit_clamped;

    // ---------------- item capture ----------------
    assign limit_clamped = (32'(in_limit) > 32'(MAX_LIMIT)) ? CNT_W'(MAX_LIMIT)
                                                             : CNT_W'(in_limit);
    assign rec_rd_addr   = CIDX_W'(in_client);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg   <= in_action;
            in_range_reg <= (32'(in_client) < 32'(CLIENTS));
            cidx_reg     <= CIDX_W'(in_client);
            limit_reg    <= limit_clamped;
            window_reg   <= in_window;
            now_reg      <= in_now;
        end
    end

    // ---------------- ring arithmetic ----------------
    assign oldest_inc = (oldest_reg == SLOT_W'(MAX_LIMIT - 1)) ? '0 : oldest_reg + 1'b1;
    assign slot_sum   = SUM_W'(oldest_reg) + SUM_W'(count_reg);
    assign slot_wrap  = (slot_sum >= SUM_W'(MAX_LIMIT)) ? slot_sum - SUM_W'(MAX_LIMIT)
                                                        : slot_sum;
    assign free_slot  = SLOT_W'(slot_wrap);
    assign age        = now_reg - stamp_rd_reg;
    assign expire_hit = (age >= rec_rd_reg.window);
    assign room       = (count_reg < rec_rd_reg.limit);
    assign count_new  = room ? count_reg + 1'b1 : count_reg;
    assign new_client = in_range_reg && (action_reg == ACTION_REGISTER) && !rec_rd_reg.valid;

    // ---------------- record memory ----------------
    always_comb
    begin
        rec_we      = 1'b0;
        rec_wr_addr = cidx_reg;
        rec_wr_data = '0;
        priority if (cmd.clear)
        begin
            rec_we      = 1'b1;
            rec_wr_addr = clr_ptr_reg;
        end
        else if (cmd.lookup)
        begin
            rec_we      = new_client;
            rec_wr_data = '{valid: 1'b1, limit: limit_reg, window: window_reg,
                            oldest: rec_rd_reg.oldest, count: rec_rd_reg.count};
        end
        else if (cmd.decide)
        begin
            rec_we      = 1'b1;
            rec_wr_data = '{valid: 1'b1, limit: rec_rd_reg.limit,
                            window: rec_rd_reg.window,
                            oldest: oldest_reg, count: count_new};
        end
        else
        begin
            rec_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_wr_addr] <= rec_wr_data;
        end
        if (cmd.load_item)
        begin
            rec_rd_reg <= rec_mem[rec_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
        end
        else if (cmd.clear && !stat.clear_done)
        begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
        end
    end

    // ---------------- timestamp memory ----------------
    // lookup fetches the oldest stamp, each expiry step fetches the next one
    assign stamp_rd_addr = cmd.lookup ? {cidx_reg, rec_rd_reg.oldest} : {cidx_reg, oldest_inc};
    assign stamp_wr_addr = {cidx_reg, free_slot};
    assign stamp_we      = cmd.decide && room;

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_wr_addr] <= now_reg;
        end
        stamp_rd_reg <= stamp_mem[stamp_rd_addr];
    end

    // ---------------- ring pointers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            oldest_reg <= rec_rd_reg.oldest;
            count_reg  <= rec_rd_reg.count;
        end
        else if (cmd.expire && expire_hit)
        begin
            oldest_reg <= oldest_inc;
            count_reg  <= count_reg - 1'b1;
        end
    end

    // ---------------- result ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            priority if (!in_range_reg)
            begin
                res_status_reg <= STATUS_NOT_FOUND;
                res_count_reg  <= '0;
            end
            else if (action_reg == ACTION_REGISTER)
            begin
                res_status_reg <= rec_rd_reg.valid ? STATUS_EXISTS : STATUS_OK;
                res_count_reg  <= rec_rd_reg.count;
            end
            else
            begin
                res_status_reg <= STATUS_NOT_FOUND;
                res_count_reg  <= rec_rd_reg.count;
            end
        end
        else if (cmd.decide)
        begin
            res_status_reg <= room ? STATUS_OK : STATUS_LIMITED;
            res_count_reg  <= count_new;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= COUNT_W'(res_count_reg);
        end
    end

    assign out_status    = out_status_reg;
    assign out_in_window = out_count_reg;

    assign stat.clear_done = (clr_ptr_reg == CIDX_W'(CLIENTS - 1));
    assign stat.in_range   = in_range_reg;
    assign stat.is_request = (action_reg == ACTION_REQUEST);
    assign stat.rec_valid  = rec_rd_reg.valid;
    assign stat.count_nz   = (rec_rd_reg.count != '0);
    assign stat.expire_hit = expire_hit;
    assign stat.more_left  = (count_reg > CNT_W'(1));

endmodule
`default_nettype wire

[rtl/sliding_window_log_rate_limiter_core.sv]
`default_nettype none
// sequence: a register request or an unregistered client goes from lookup to finish; a rate
//   check runs lookup, the expiry walk when stamps are stored, decide and finish, the walk
//   examining one stored stamp per step through the one-read-per-cycle stamp memory port
// throughput: one request in flight; the next is taken only after the previous one leaves
//   finish, which waits while the output register still holds an untaken result
// reset: asynchronous; the client table is swept clear before input opens
// ----------------------------------------------------------------------------
// sliding_window_log_rate_limiter_core
// Per-client sliding-window-log rate limiter: registers clients with a limit
// and a window, and admits or refuses requests against each client's log.
// ----------------------------------------------------------------------------
module sliding_window_log_rate_limiter_core
#(
    parameter int CLIENTS   = 16,
    parameter int MAX_LIMIT = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    swlrl_req_if.sink      req,
    swlrl_resp_if.source   resp
);
    import swlrl_pkg::*;

    // command and status bundles between the sequencer and the datapath
    swlrl_cmd_t  cmd;
    swlrl_stat_t stat;

    // sequencer
    //   clear sweep after reset, then per request:
    //   idle -> lookup -> (expiry walk) -> decide -> finish
    //   register requests and unknown or out-of-range clients skip straight to finish
    swlrl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (resp.valid),
        .out_ready (resp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    //   client record memory: valid, clamped limit, window, ring head, count
    //   timestamp memory: one ring of MAX_LIMIT stamps per client
    //   expiry pops the oldest stamp while now - stamp >= window
    //   admission appends now when the count is below the limit
    swlrl_dp
    #(
        .CLIENTS   (CLIENTS),
        .MAX_LIMIT (MAX_LIMIT)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_action     (req.action),
        .in_client     (req.client),
        .in_limit      (req.limit),
        .in_window     (req.window),
        .in_now        (req.now),
        .out_status    (resp.status),
        .out_in_window (resp.in_window)
    );

endmodule
`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding-window-log rate limiter core. A driver
// feeds register and rate-check requests from a queue, and a checker predicts
// each answer from its own copy of the client table and timestamp logs. The
// checker compares every response against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import swlrl_pkg::*;

    localparam int CLIENTS    = 16;
    localparam int MAX_LIMIT  = 16;
    localparam int RAND_REQS  = 600;
    localparam int QUIET_MAX  = 3000;   // cycles with no handshake before giving up
    localparam int TAIL_WAIT  = 40;     // settle time after the last answer

    typedef struct
    {
        swlrl_action_t        action;
        logic [CLIENT_W-1:0]  client;
        logic [LIMIT_W-1:0]   limit;
        logic [TIME_W-1:0]    window;
        logic [TIME_W-1:0]    now;
        bit                   drain;    // hold back until every answer is in
    } limiter_req_t;

    typedef struct
    {
        swlrl_status_t        status;
        logic [COUNT_W-1:0]   in_window;
    } limiter_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    swlrl_req_if  req_ch();
    swlrl_resp_if resp_ch();

    sliding_window_log_rate_limiter_core
    #(
        .CLIENTS   (CLIENTS),
        .MAX_LIMIT (MAX_LIMIT)
    )
    dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .resp  (resp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow of the limiter state: client table plus one ring log per client
    // ------------------------------------------------------------------------
    bit                   client_on   [CLIENTS];
    logic [COUNT_W-1:0]   client_cap  [CLIENTS];
    logic [TIME_W-1:0]    client_span [CLIENTS];
    logic [TIME_W-1:0]    log_stamp   [CLIENTS][MAX_LIMIT];
    int                   log_oldest  [CLIENTS];
    int                   log_held    [CLIENTS];

    limiter_req_t         pending[$];          // requests not yet accepted
    limiter_answer_t      expected_answers[$]; // predictions awaiting a response
    logic [TIME_W-1:0]    clock_now;           // time stamp for the next request
    int                   req_total = 0;
    int                   sent_cnt  = 0;
    int                   fail_count = 0;

    // one step of the limiter: register or rate check, returns the answer
    function automatic limiter_answer_t limiter_answer(swlrl_action_t act,
        logic [CLIENT_W-1:0] cl, logic [LIMIT_W-1:0] lim, logic [TIME_W-1:0] win,
        logic [TIME_W-1:0] t);
        limiter_answer_t   a;
        logic [TIME_W-1:0] age;
        bit                walking;
        a.status = STATUS_OK;
        if (act == ACTION_REGISTER)
        begin
            if (client_on[cl])
            begin
                a.status = STATUS_EXISTS;
            end
            else
            begin
                client_on[cl]   = 1'b1;
                client_cap[cl]  = (lim > MAX_LIMIT) ? COUNT_W'(MAX_LIMIT) : lim;
                client_span[cl] = win;
            end
        end
        else if (!client_on[cl])
        begin
            a.status = STATUS_NOT_FOUND;
        end
        else
        begin
            // expiry walk, oldest stamp first; age wraps modulo 2^32
            walking = 1'b1;
            while (walking && log_held[cl] != 0)
            begin
                age = t - log_stamp[cl][log_oldest[cl]];
                if (age < client_span[cl])
                begin
                    walking = 1'b0;
                end
                else
                begin
                    log_oldest[cl] = (log_oldest[cl] + 1) % MAX_LIMIT;
                    log_held[cl]   = log_held[cl] - 1;
                end
            end
            if (log_held[cl] < client_cap[cl])
            begin
                log_stamp[cl][(log_oldest[cl] + log_held[cl]) % MAX_LIMIT] = t;
                log_held[cl] = log_held[cl] + 1;
            end
            else
            begin
                a.status = STATUS_LIMITED;
            end
        end
        a.in_window = COUNT_W'(log_held[cl]);
        return a;
    endfunction

    // idle percentage for the current run phase, by side
    function automatic int idle_pct(bit sender_side);
        int phase;
        phase = (req_total == 0) ? 0 : (sent_cnt * 3) / req_total;
        case (phase)
            0:       return sender_side ? 19 : 72;
            1:       return sender_side ? 72 : 19;
            default: return 0;
        endcase
    endfunction

    task automatic push_item(swlrl_action_t act, int cl, int lim,
        logic [TIME_W-1:0] win, bit drain);
        limiter_req_t r;
        r.action = act;
        r.client = CLIENT_W'(cl);
        r.limit  = LIMIT_W'(lim);
        r.window = win;
        r.now    = clock_now;
        r.drain  = drain;
        pending.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // driver: holds a request until it is taken, then picks the next one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive
        bit           fire;
        bit           go;
        fire = req_ch.valid && req_ch.ready;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || fire)
        begin
            if (fire)
            begin
                void'(pending.pop_front());
                sent_cnt <= sent_cnt + 1;
            end
            go = 1'b0;
            if (pending.size() != 0)
            begin
                go = ($urandom_range(99) >= idle_pct(1'b1));
                // a drain marker waits for the just-taken request as well
                if (pending[0].drain && (fire || expected_answers.size() != 0))
                    go = 1'b0;
            end
            if (go)
            begin
                req_ch.valid  <= 1'b1;
                req_ch.action <= pending[0].action;
                req_ch.client <= pending[0].client;
                req_ch.limit  <= pending[0].limit;
                req_ch.window <= pending[0].window;
                req_ch.now    <= pending[0].now;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(posedge clk)
    begin
        resp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end

    // ------------------------------------------------------------------------
    // checker: compare each response, then predict for a newly taken request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check
        limiter_answer_t want;
        if (rst_n)
        begin
            if (resp_ch.valid && resp_ch.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected response: status %s in_window %0d",
                           resp_ch.status.name(), resp_ch.in_window);
                    fail_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (resp_ch.status !== want.status)
                    begin
                        $error("status: expected %s, got %s",
                               want.status.name(), resp_ch.status.name());
                        fail_count++;
                    end
                    if (resp_ch.in_window !== want.in_window)
                    begin
                        $error("in_window: expected %0d, got %0d",
                               want.in_window, resp_ch.in_window);
                        fail_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                expected_answers.push_back(limiter_answer(
                    swlrl_action_t'(req_ch.action), req_ch.client, req_ch.limit,
                    req_ch.window, req_ch.now));
            end
        end
    end

    // watchdog on handshake activity
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** sliding_window_log_rate_limiter_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int r;
        int cl;
        int lim;
        logic [TIME_W-1:0] win;

        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACTION_REGISTER;
        req_ch.client  = '0;
        req_ch.limit   = '0;
        req_ch.window  = '0;
        req_ch.now     = '0;
        resp_ch.ready  = 1'b0;
        for (int c = 0; c < CLIENTS; c++)
        begin
            client_on[c]  = 1'b0;
            log_oldest[c] = 0;
            log_held[c]   = 0;
        end

        // start close to the top of the time range so it wraps during the run
        clock_now = 32'hFFFF_F000;

        // directed part
        push_item(ACTION_REQUEST, 7, $urandom_range(31), $urandom, 1'b0); // unknown client
        push_item(ACTION_REGISTER, 0, 0, 32'd100, 1'b0);                  // zero limit
        push_item(ACTION_REGISTER, 0, 5, 32'd7, 1'b0);                    // already there
        push_item(ACTION_REQUEST, 0, 0, 0, 1'b0);                         // always refused
        push_item(ACTION_REGISTER, 15, 31, 32'hFFFF_FFFF, 1'b0);          // clamp, widest window
        push_item(ACTION_REGISTER, 5, 17, 32'd0, 1'b0);                   // zero window
        push_item(ACTION_REQUEST, 5, 31, 32'hFFFF_FFFF, 1'b0);
        push_item(ACTION_REQUEST, 5, 0, 0, 1'b0);                         // same tick, stamp gone
        push_item(ACTION_REGISTER, 3, 1, 32'd5, 1'b1);
        push_item(ACTION_REQUEST, 3, 0, 0, 1'b0);
        push_item(ACTION_REQUEST, 3, 0, 0, 1'b0);                         // over the limit
        clock_now = clock_now + 5;                                        // exactly one window
        push_item(ACTION_REQUEST, 3, 0, 0, 1'b0);
        // fill client 15 past the clamped depth
        for (int i = 0; i < MAX_LIMIT + 1; i++)
        begin
            clock_now = clock_now + 1;
            push_item(ACTION_REQUEST, 15, $urandom_range(31), $urandom, 1'b0);
        end

        // random part: mostly rate checks against a slowly advancing clock
        for (int i = 0; i < RAND_REQS; i++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                clock_now = clock_now + $urandom_range(2);
            else if (r < 90)
                clock_now = clock_now + $urandom_range(15, 3);
            else
                clock_now = clock_now + $urandom_range(3000, 50);
            cl = $urandom_range(CLIENTS - 1);
            r = $urandom_range(99);
            if (r < 12)
            begin
                lim = ($urandom_range(99) < 70) ? $urandom_range(6, 1) : $urandom_range(31);
                r = $urandom_range(99);
                if (r < 70)
                    win = $urandom_range(60, 1);
                else if (r < 80)
                    win = '0;
                else
                    win = $urandom;
                push_item(ACTION_REGISTER, cl, lim, win, (i % 150) == 149);
            end
            else
            begin
                push_item(ACTION_REQUEST, cl, $urandom_range(31), $urandom, (i % 150) == 149);
            end
        end
        req_total = pending.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge so the driver and checker have settled
        while (pending.size() != 0 || expected_answers.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("** sliding_window_log_rate_limiter_core: PASSED **");
        else
            $display("** sliding_window_log_rate_limiter_core: FAILED **");
        $finish;
    end

endmodule

[files.f]
rtl/swlrl_pkg.sv
rtl/swlrl_req_if.sv
rtl/swlrl_resp_if.sv
rtl/swlrl_ctrl.sv
rtl/swlrl_dp.sv
rtl/sliding_window_log_rate_limiter_core.sv
sim/tb.sv
